// File: rtl/gaussian_pyramid_reduce_defines.svh
// Assertion macros used by the checker file of the pyramid reduce block.
`ifndef GAUSSIAN_PYRAMID_REDUCE_DEFINES_SVH
`define GAUSSIAN_PYRAMID_REDUCE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GPR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/gpr_pkg.sv
// Package of the pyramid reduce block: sizes, register codes, job type and helpers.
package gpr_pkg;

  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT_DEF  = 4096;
  localparam int PIXEL_BITS_DEF  = 8;
  localparam int WIDTH_REG_BITS  = 11;
  localparam int HEIGHT_REG_BITS = 13;
  localparam int COL_BITS        = 9;
  localparam int ROW_BITS        = 11;
  localparam int QUEUE_DEPTH     = 4;
  localparam int ADDR_BITS       = 3;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  // One queued job: the outputs that one input pixel completes.
  typedef struct packed {
    logic [1:0]          dy_first;
    logic [1:0]          ny;
    logic [1:0]          dx_first;
    logic [1:0]          nx;
    logic [ROW_BITS-1:0] orow;
    logic [COL_BITS-1:0] ocol;
    logic                frame;
  } job_meta_t;

  function automatic logic [2:0] tap_weight(input logic [2:0] i);
    logic [2:0] w;
    case (i)
      3'd0:    w = 3'd1;
      3'd1:    w = 3'd4;
      3'd2:    w = 3'd6;
      3'd3:    w = 3'd4;
      3'd4:    w = 3'd1;
      default: w = 3'd0;
    endcase
    return w;
  endfunction

  // Window index of tap i for a centre that lies d places before the newest one.
  function automatic logic [2:0] win_sel(input logic [1:0] d, input logic [2:0] i);
    logic [3:0] t;
    t = {2'b00, d} + 4'd2 - {1'b0, i};
    if (t[3]) return 3'd4;
    return 3'd4 - t[2:0];
  endfunction

endpackage

// File: rtl/gpr_front.sv
// Front end: position counters, line stores, window and job classification.
module gpr_front import gpr_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [WIDTH_REG_BITS-1:0]    image_width,
  input  logic [HEIGHT_REG_BITS-1:0]   image_height,
  input  logic                         in_valid,
  input  logic [PIXEL_BITS-1:0]        pixel,
  output logic                         in_stall,
  input  logic                         q_full,
  output logic                         push,
  output job_meta_t                    push_meta,
  output logic [25*PIXEL_BITS-1:0]     push_win
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic adv, acc;
  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic [31:0] w_eff, h_eff;
  logic [CW-1:0] cu, wl;
  logic [RW-1:0] ru, hl;
  logic last_col, last_row;
  job_meta_t meta;
  logic [PIXEL_BITS-1:0] rd [4];

  logic                  s1_valid;
  logic [PIXEL_BITS-1:0] s1_p;
  logic [RW-1:0]         s1_r;
  logic                  s1_c0;
  job_meta_t             s1_meta;

  logic [PIXEL_BITS-1:0] win [5][5];
  logic [PIXEL_BITS-1:0] win_next [5][5];
  logic [PIXEL_BITS-1:0] v [5];

  assign adv      = !q_full;
  assign in_stall = !adv;
  assign acc      = in_valid && adv;

  always_comb begin
    if (image_width == '0) w_eff = 32'd1;
    else if (32'(image_width) > 32'(MAX_WIDTH)) w_eff = 32'(MAX_WIDTH);
    else w_eff = 32'(image_width);
    if (image_height == '0) h_eff = 32'd1;
    else if (32'(image_height) > 32'(MAX_HEIGHT)) h_eff = 32'(MAX_HEIGHT);
    else h_eff = 32'(image_height);
    wl = CW'(w_eff - 32'd1);
    hl = RW'(h_eff - 32'd1);
    cu = (col_count < wl) ? col_count : wl;
    ru = (row_count < hl) ? row_count : hl;
    last_col = (cu == wl);
    last_row = (ru == hl);
  end

  // Which even rows and columns this pixel completes, counted back from it.
  always_comb begin
    meta = '0;
    if (last_row) begin
      if (!ru[0]) begin
        meta.ny       = (ru >= RW'(2)) ? 2'd2 : 2'd1;
        meta.dy_first = (ru >= RW'(2)) ? 2'd2 : 2'd0;
      end else begin
        meta.ny       = 2'd1;
        meta.dy_first = 2'd1;
      end
    end else if (!ru[0] && ru >= RW'(2)) begin
      meta.ny       = 2'd1;
      meta.dy_first = 2'd2;
    end
    if (last_col) begin
      if (!cu[0]) begin
        meta.nx       = (cu >= CW'(2)) ? 2'd2 : 2'd1;
        meta.dx_first = (cu >= CW'(2)) ? 2'd2 : 2'd0;
      end else begin
        meta.nx       = 2'd1;
        meta.dx_first = 2'd1;
      end
    end else if (!cu[0] && cu >= CW'(2)) begin
      meta.nx       = 2'd1;
      meta.dx_first = 2'd2;
    end
    meta.orow  = ROW_BITS'(32'(ru - RW'(meta.dy_first)) >> 1);
    meta.ocol  = COL_BITS'(32'(cu - CW'(meta.dx_first)) >> 1);
    meta.frame = last_row && last_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      s1_valid  <= 1'b0;
    end else begin
      if (acc) begin
        if (last_col) begin
          col_count <= '0;
          row_count <= last_row ? '0 : ru + RW'(1);
        end else begin
          col_count <= cu + CW'(1);
          row_count <= ru;
        end
      end
      if (adv) s1_valid <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_p    <= pixel;
      s1_r    <= ru;
      s1_c0   <= (cu == '0);
      s1_meta <= meta;
    end
  end

  // Row q of the image lives in line store q mod 4.
  for (genvar g = 0; g < 4; g++) begin : g_line
    logic [PIXEL_BITS-1:0] mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (acc && ru[1:0] == 2'(g)) mem[cu] <= pixel;
      if (adv) rd[g] <= mem[cu];
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (s1_r == '0) v[k] = s1_p;
      else if (32'(s1_r) < 32'(4 - k)) v[k] = rd[0];
      else v[k] = rd[2'(32'(s1_r) + 32'(k))];
    end
    v[4] = s1_p;
    for (int k = 0; k < 5; k++) begin
      for (int j = 0; j < 4; j++) win_next[k][j] = s1_c0 ? v[k] : win[k][j+1];
      win_next[k][4] = v[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) win <= win_next;
  end

  always_comb begin
    for (int k = 0; k < 5; k++)
      for (int j = 0; j < 5; j++)
        push_win[(k*5+j)*PIXEL_BITS +: PIXEL_BITS] = win_next[k][j];
  end

  assign push      = adv && s1_valid && s1_meta.ny != 2'd0 && s1_meta.nx != 2'd0;
  assign push_meta = s1_meta;

endmodule

// File: rtl/gpr_queue.sv
// Small job queue between the front end and the blur back end.
module gpr_queue import gpr_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0] count;

  assign full       = (count == (PW+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop) rd_ptr <= rd_ptr + PW'(1);
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

// File: rtl/gpr_back.sv
// Back end: walks the outputs of each job and computes the separable blur.
module gpr_back import gpr_pkg::*; #(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     head_valid,
  input  job_meta_t                head_meta,
  input  logic [25*PIXEL_BITS-1:0] head_win,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [PIXEL_BITS-1:0]    reduced_value,
  output logic [COL_BITS-1:0]      out_col,
  output logic [ROW_BITS-1:0]      out_row,
  output logic                     last_of_run,
  output logic                     frame_done
);

  localparam int VW = PIXEL_BITS + 4;
  localparam int HW = PIXEL_BITS + 9;

  logic adv, issue, last_x, last_y;
  logic yi, xi;
  logic [1:0] dy, dx;
  logic [VW-1:0] vsum [5];

  logic                a_valid;
  logic [VW-1:0]       a_v [5];
  logic [1:0]          a_dx;
  logic [ROW_BITS-1:0] a_row;
  logic [COL_BITS-1:0] a_col;
  logic                a_last, a_frame;
  logic [HW-1:0]       hsum;

  assign adv    = !out_valid || !out_stall;
  assign issue  = adv && head_valid;
  assign last_x = ({1'b0, xi} == head_meta.nx - 2'd1);
  assign last_y = ({1'b0, yi} == head_meta.ny - 2'd1);
  assign pop    = issue && last_x && last_y;
  assign dy     = head_meta.dy_first - {yi, 1'b0};
  assign dx     = head_meta.dx_first - {xi, 1'b0};

  always_comb begin
    for (int j = 0; j < 5; j++) begin
      vsum[j] = '0;
      for (int i = 0; i < 5; i++)
        vsum[j] = vsum[j] + VW'(tap_weight(3'(i))) *
                  VW'(head_win[(32'(win_sel(dy, 3'(i))) * 5 + j) * PIXEL_BITS +: PIXEL_BITS]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      yi      <= 1'b0;
      xi      <= 1'b0;
      a_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      a_valid   <= issue;
      out_valid <= a_valid;
      if (issue) begin
        if (last_x) begin
          xi <= 1'b0;
          yi <= last_y ? 1'b0 : 1'b1;
        end else begin
          xi <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_v     <= vsum;
      a_dx    <= dx;
      a_row   <= head_meta.orow + ROW_BITS'(yi);
      a_col   <= head_meta.ocol + COL_BITS'(xi);
      a_last  <= last_x && last_y;
      a_frame <= last_x && last_y && head_meta.frame;
    end
  end

  always_comb begin
    hsum = HW'(128);
    for (int i = 0; i < 5; i++)
      hsum = hsum + HW'(tap_weight(3'(i))) * HW'(a_v[win_sel(a_dx, 3'(i))]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      reduced_value <= hsum[PIXEL_BITS+7:8];
      out_col       <= a_col;
      out_row       <= a_row;
      last_of_run   <= a_last;
      frame_done    <= a_frame;
    end
  end

endmodule

// File: rtl/gaussian_pyramid_reduce.sv
// Top level of the 5x5 binomial pyramid reduce block with its register port.
//
//   channel   direction   handshake             payload
//   input     in          in_valid / in_stall   pixel
//   output    out         out_valid / out_stall reduced_value, out_col, out_row,
//                                               last_of_run, frame_done
//   config    in          psel/penable/pwrite   paddr, pwdata (prdata back)
//
// One pixel is taken per clock while the job queue has room.
// A pixel that completes several results holds the blur unit while it issues them,
// and a four-entry job queue absorbs these bursts before the input stalls.
// Synchronous reset clears counters, queue and valids; line stores need no clearing.
// A stall on the output freezes the blur pipeline and, once the queue fills, the input.
module gaussian_pyramid_reduce import gpr_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_BITS-1:0]  paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid,
  input  logic [PIXEL_BITS-1:0] pixel,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIXEL_BITS-1:0] reduced_value,
  output logic [COL_BITS-1:0]   out_col,
  output logic [ROW_BITS-1:0]   out_row,
  output logic                  last_of_run,
  output logic                  frame_done
);

  localparam int QW = $bits(job_meta_t) + 25 * PIXEL_BITS;

  logic [WIDTH_REG_BITS-1:0]  image_width;
  logic [HEIGHT_REG_BITS-1:0] image_height;
  reg_idx_t reg_sel;
  logic q_full, push, pop, head_valid;
  job_meta_t push_meta;
  logic [25*PIXEL_BITS-1:0] push_win;
  logic [QW-1:0] head_data;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_REG_BITS'(1024);
      image_height <= HEIGHT_REG_BITS'(1024);
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_WIDTH:  image_width  <= pwdata[WIDTH_REG_BITS-1:0];
        REG_HEIGHT: image_height <= pwdata[HEIGHT_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WIDTH:  prdata = 32'(image_width);
      REG_HEIGHT: prdata = 32'(image_height);
      default:    prdata = '0;
    endcase
  end

  gpr_front #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .PIXEL_BITS(PIXEL_BITS)
  ) u_front (
    .clk, .rst, .image_width, .image_height, .in_valid, .pixel, .in_stall,
    .q_full, .push, .push_meta, .push_win
  );

  gpr_queue #(.WIDTH(QW)) u_queue (
    .clk, .rst, .push, .push_data({push_meta, push_win}), .full(q_full),
    .pop, .head_valid, .head_data
  );

  gpr_back #(.PIXEL_BITS(PIXEL_BITS)) u_back (
    .clk, .rst, .head_valid,
    .head_meta(job_meta_t'(head_data[QW-1 -: $bits(job_meta_t)])),
    .head_win(head_data[25*PIXEL_BITS-1:0]),
    .pop, .out_valid, .out_stall, .reduced_value, .out_col, .out_row,
    .last_of_run, .frame_done
  );

endmodule

// File: rtl/gpr_checker.sv
// Port-level checks of the pyramid reduce output stream, bound to the top level.
`include "gaussian_pyramid_reduce_defines.svh"

module gpr_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input logic last_of_run,
  input logic frame_done
);

  `GPR_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid, "output request dropped under stall")
  `GPR_ASSERT_NOW(a_frame_last, clk, rst, out_valid && frame_done, last_of_run, "frame end not last of run")
  `GPR_ASSERT_NEXT(a_run_burst, clk, rst, out_valid && !out_stall && !last_of_run, out_valid, "gap inside a run of results")
  `GPR_ASSERT_NOW(a_frame_only_last, clk, rst, out_valid && !last_of_run, !frame_done, "frame end inside a run")

endmodule

bind gaussian_pyramid_reduce gpr_checker u_checker (
  .clk, .rst, .out_valid, .out_stall, .last_of_run, .frame_done
);
